// ----- rtl/core/cts_pkg.sv -----
// Package for the cooperative thread scheduler: payload widths, request kinds,
// status codes, controller states and the controller/datapath command types.
// No dependencies.
package cts_pkg;

	localparam int KIND_W         = 4;
	localparam int TGT_W          = 5;
	localparam int SEMH_W         = 3;
	localparam int INIT_W         = 16;
	localparam int STATUS_W       = 3;
	localparam int ID_W           = 5;
	localparam int MAIN_THREAD_ID = 1;

	typedef enum logic [KIND_W-1:0] {
		K_INIT        = 4'd0,
		K_CREATE      = 4'd1,
		K_YIELD       = 4'd2,
		K_JOIN        = 4'd3,
		K_JOIN_ALL    = 4'd4,
		K_EXIT        = 4'd5,
		K_SEM_INIT    = 4'd6,
		K_SEM_SIGNAL  = 4'd7,
		K_SEM_WAIT    = 4'd8,
		K_SEM_DESTROY = 4'd9
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_NOT_CHILD = 3'd1,
		STS_SEM_BUSY  = 3'd2,
		STS_NO_THREAD = 3'd3,
		STS_NO_SEM    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_JA_SCAN,
		S_JA_END,
		S_EX_SCAN,
		S_EX_WAKE,
		S_SEM_POP,
		S_DISP_RD,
		S_DISP_WR,
		S_FINISH
	} ctl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_EXEC,
		OP_JA_STEP,
		OP_JA_END,
		OP_EX_STEP,
		OP_EX_WAKE,
		OP_SEM_PUSH,
		OP_DISP_RD,
		OP_DISP_WR,
		OP_RESULT
	} dp_op_t;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_DISPATCH,
		PH_JA,
		PH_EX,
		PH_POP
	} phase_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		phase_t exec_next;
		logic   ja_last;
		logic   ex_last;
		logic   ja_take;
		logic   out_free;
	} dp_stat_t;

endpackage

// ----- rtl/core/cts_intf.sv -----
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on cts_pkg.
interface cts_req_if;
	import cts_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic [TGT_W-1:0]         target_thread;
	logic [SEMH_W-1:0]        sem_handle;
	logic signed [INIT_W-1:0] sem_initial;

	modport source (output valid, kind, target_thread, sem_handle, sem_initial, input ready);
	modport sink   (input valid, kind, target_thread, sem_handle, sem_initial, output ready);
endinterface

interface cts_rsp_if;
	import cts_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     running_thread;
	logic                idle;
	logic [ID_W-1:0]     new_handle;

	modport source (output valid, status, running_thread, idle, new_handle, input ready);
	modport sink   (input valid, status, running_thread, idle, new_handle, output ready);
endinterface

// ----- rtl/core/cooperative_thread_scheduler_top.sv -----
// Cooperative thread scheduler top level; depends on cts_pkg, cts_intf, cts_ctrl, cts_dpath.
// A request passes the execute and result states; a waking signal adds a wait list pop,
// a dispatch a ready queue read and write; join_all scans the ready queue, dispatching
// if it blocks; exit walks one thread table entry per cycle, wakes the parent, dispatches.
// One request in flight; the next is taken as soon as the result is registered.
// Reset clears all control state at once; no clearing pass is needed.
module cooperative_thread_scheduler_top #(
	parameter int MAX_THREADS    = 16,
	parameter int MAX_SEMAPHORES = 8,
	parameter int COUNT_BITS     = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cts_req_if.sink    req,
	cts_rsp_if.source  rsp
);
	import cts_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cts_dpath #(
		.MAX_THREADS    (MAX_THREADS),
		.MAX_SEMAPHORES (MAX_SEMAPHORES),
		.COUNT_BITS     (COUNT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_kind     (req.kind),
		.in_target   (req.target_thread),
		.in_sem      (req.sem_handle),
		.in_initial  (req.sem_initial),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_running (rsp.running_thread),
		.out_idle    (rsp.idle),
		.out_handle  (rsp.new_handle)
	);

	// a request transaction closes the request side until its result is registered
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	// a result cannot appear in the cycle after a request transaction
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !$rose(rsp.valid))
		else $error("result registered too early");

	// idle flag tracks the running thread
	a_idle_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.idle == (rsp.running_thread == '0)))
		else $error("idle flag disagrees with running thread");

endmodule

// ----- rtl/core/cts_ctrl.sv -----
// Scheduler controller: sequences one request through execute, scan, wake,
// semaphore pop, dispatch and result phases. Depends on cts_pkg.
module cts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cts_pkg::dp_stat_t stat,
	output cts_pkg::dp_cmd_t  cmd
);
	import cts_pkg::*;

	ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.op = OP_EXEC;
				case (stat.exec_next)
					PH_DISPATCH: state_d = S_DISP_RD;
					PH_JA:       state_d = S_JA_SCAN;
					PH_EX:       state_d = S_EX_SCAN;
					PH_POP:      state_d = S_SEM_POP;
					default:     state_d = S_FINISH;
				endcase
			end
			S_JA_SCAN: begin
				cmd.op = OP_JA_STEP;
				if (stat.ja_last) state_d = S_JA_END;
			end
			S_JA_END: begin
				cmd.op  = OP_JA_END;
				state_d = stat.ja_take ? S_DISP_RD : S_FINISH;
			end
			S_EX_SCAN: begin
				cmd.op = OP_EX_STEP;
				if (stat.ex_last) state_d = S_EX_WAKE;
			end
			S_EX_WAKE: begin
				cmd.op  = OP_EX_WAKE;
				state_d = S_DISP_RD;
			end
			S_SEM_POP: begin
				cmd.op  = OP_SEM_PUSH;
				state_d = S_FINISH;
			end
			S_DISP_RD: begin
				cmd.op  = OP_DISP_RD;
				state_d = S_DISP_WR;
			end
			S_DISP_WR: begin
				cmd.op  = OP_DISP_WR;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/core/cts_dpath.sv -----
// Scheduler datapath: ready queue, thread table, semaphore table, semaphore
// wait lists and the result register. Depends on cts_pkg.
module cts_dpath #(
	parameter int MAX_THREADS    = 16,
	parameter int MAX_SEMAPHORES = 8,
	parameter int COUNT_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cts_pkg::dp_cmd_t                    cmd,
	output cts_pkg::dp_stat_t                   stat,
	input  logic [cts_pkg::KIND_W-1:0]          in_kind,
	input  logic [cts_pkg::TGT_W-1:0]           in_target,
	input  logic [cts_pkg::SEMH_W-1:0]          in_sem,
	input  logic signed [cts_pkg::INIT_W-1:0]   in_initial,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cts_pkg::STATUS_W-1:0]        out_status,
	output logic [cts_pkg::ID_W-1:0]            out_running,
	output logic                                out_idle,
	output logic [cts_pkg::ID_W-1:0]            out_handle
);
	import cts_pkg::*;

	localparam int MT = MAX_THREADS;
	localparam int MS = MAX_SEMAPHORES;
	localparam int CB = COUNT_BITS;
	localparam int TW = $clog2(MAX_THREADS);
	localparam int IW = $clog2(MAX_THREADS + 1);
	localparam int NW = $clog2(MAX_THREADS + 2);
	localparam int SW = (MAX_SEMAPHORES > 1) ? $clog2(MAX_SEMAPHORES) : 1;
	localparam int AW = $clog2(MAX_SEMAPHORES * MAX_THREADS);
	localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

	// latched request
	logic [KIND_W-1:0]        kind_q;
	logic [TGT_W-1:0]         tgt_q;
	logic [SEMH_W-1:0]        sh_q;
	logic signed [INIT_W-1:0] init_q;

	// ready queue
	logic [IW-1:0] rq_mem [MT];
	logic [IW-1:0] rq_rdata_q;
	logic [TW-1:0] rhead_q;
	logic [IW-1:0] rcount_q;

	// thread table
	logic [IW-1:0] running_q;
	logic [NW-1:0] next_q;
	logic [IW-1:0] parent_q [MT];
	logic [IW-1:0] waits_q [MT];
	logic [MT-1:0] live_q, fin_q, blk_q;

	// semaphore table and wait lists
	logic signed [CB-1:0] sval_q [MS];
	logic [MS-1:0]        sused_q;
	logic [TW-1:0]        shead_q [MS];
	logic [IW-1:0]        scnt_q [MS];
	logic [IW-1:0]        sw_mem [MS*MT];
	logic [IW-1:0]        sw_rdata_q;

	// scan and result working registers
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       par_q;
	logic                any_q, jv_q, hc_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     handle_q;
	logic                ov_q;
	logic [STATUS_W-1:0] ost_q;
	logic [ID_W-1:0]     orun_q, ohd_q;

	// combinational
	logic [IW-1:0]        main_id;
	logic                 create_ok;
	logic [TW-1:0]        create_slot;
	logic [TGT_W-1:0]     tgt_m1;
	logic [TW-1:0]        tgt_slot;
	logic                 tgt_ok, j_bad1, j_bad2, j_fin, join_block;
	logic [TW-1:0]        run_slot;
	logic [SW-1:0]        si;
	logic                 sem_ok;
	logic signed [CB-1:0] sval_cur, sig_inc, wait_dec, init_clamp;
	logic signed [32:0]   init_x;
	logic [TW-1:0]        shead_cur;
	logic [IW-1:0]        scnt_cur;
	logic                 sig_pop, wait_block, wait_store;
	logic                 free_found;
	logic [SW-1:0]        free_idx;
	logic [AW-1:0]        sw_base, sw_raddr, sw_waddr;
	logic [IW:0]          stail_sum, rtail_sum, rptr_sum;
	logic [TW-1:0]        stail, rtail, ja_ptr;
	logic [IW-1:0]        ja_id;
	logic [TW-1:0]        ja_slot, ex_slot, par_slot;
	logic                 ja_hit, ex_live, hit_par, hit_me, par_ok, wake, wake_clear;
	logic [IW-1:0]        new_par;
	logic                 push_req, rq_we, sw_we;
	logic [IW-1:0]        push_id;
	logic [TW-1:0]        rq_raddr;
	phase_t               phase;

	assign main_id = IW'(MAIN_THREAD_ID);

	// create
	assign create_ok   = (next_q != '0) && (32'(next_q) <= MT);
	assign create_slot = TW'(next_q - NW'(1));

	// join checks
	assign tgt_m1     = tgt_q - TGT_W'(1);
	assign tgt_slot   = TW'(tgt_m1);
	assign tgt_ok     = (tgt_q != '0) && (32'(tgt_q) <= MT);
	assign j_bad1     = !tgt_ok || !live_q[tgt_slot];
	assign j_fin      = fin_q[tgt_slot];
	assign j_bad2     = (running_q == '0) || (parent_q[tgt_slot] != running_q);
	assign join_block = !j_bad1 && !j_fin && !j_bad2;
	assign run_slot   = TW'(running_q - IW'(1));

	// semaphore select and saturating count
	assign si        = SW'(sh_q);
	assign sem_ok    = (32'(sh_q) < MS) && sused_q[si];
	assign sval_cur  = sval_q[si];
	assign shead_cur = shead_q[si];
	assign scnt_cur  = scnt_q[si];
	assign sig_inc   = (sval_cur == CMAX) ? sval_cur : sval_cur + CB'(1);
	assign wait_dec  = (sval_cur == CMIN) ? sval_cur : sval_cur - CB'(1);
	assign init_x    = 33'(init_q);
	assign init_clamp = (init_x > 33'(CMAX)) ? CMAX :
	                    (init_x < 33'(CMIN)) ? CMIN : CB'(init_x);
	assign sig_pop    = sem_ok && (sig_inc[CB-1] || sig_inc == '0) && (scnt_cur != '0);
	assign wait_block = sem_ok && wait_dec[CB-1] && (running_q != '0);
	assign wait_store = wait_block && (scnt_cur < IW'(MT));

	// wait list addressing
	assign stail_sum = (IW+1)'(shead_cur) + (IW+1)'(scnt_cur);
	assign stail     = (stail_sum >= (IW+1)'(MT)) ? TW'(stail_sum - (IW+1)'(MT))
	                                              : TW'(stail_sum);
	assign sw_base   = AW'(32'(si) * MT);
	assign sw_raddr  = sw_base + AW'(shead_cur);
	assign sw_waddr  = sw_base + AW'(stail);

	// ready queue addressing
	assign rtail_sum = (IW+1)'(rhead_q) + (IW+1)'(rcount_q);
	assign rtail     = (rtail_sum >= (IW+1)'(MT)) ? TW'(rtail_sum - (IW+1)'(MT))
	                                              : TW'(rtail_sum);
	assign rptr_sum  = (IW+1)'(rhead_q) + (IW+1)'(idx_q);
	assign ja_ptr    = (rptr_sum >= (IW+1)'(MT)) ? TW'(rptr_sum - (IW+1)'(MT))
	                                             : TW'(rptr_sum);

	// first free semaphore
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MS - 1; i >= 0; i--) begin
			if (!sused_q[i]) begin
				free_found = 1'b1;
				free_idx   = SW'(i);
			end
		end
	end

	// join_all: ready entry read last cycle is a child of the running thread
	assign ja_id   = rq_rdata_q;
	assign ja_slot = TW'(ja_id - IW'(1));
	assign ja_hit  = jv_q && (ja_id != '0) && live_q[ja_slot] && !fin_q[ja_slot]
	                 && (parent_q[ja_slot] == running_q);

	// exit: thread table walk and parent wake-up
	assign ex_slot    = idx_q[TW-1:0];
	assign ex_live    = live_q[ex_slot] && !fin_q[ex_slot];
	assign hit_par    = ex_live && (parent_q[ex_slot] == par_q);
	assign hit_me     = ex_live && (parent_q[ex_slot] == running_q);
	assign new_par    = (running_q == main_id) ? '0 : main_id;
	assign par_ok     = (par_q != '0) && (32'(par_q) <= MT);
	assign par_slot   = TW'(par_q - IW'(1));
	assign wake_clear = par_ok && blk_q[par_slot] && (waits_q[par_slot] == running_q);
	assign wake       = par_ok && blk_q[par_slot] && (wake_clear || !hc_q);

	// phase decision, queue pushes and memory ports
	always_comb begin
		phase    = PH_DONE;
		push_req = 1'b0;
		push_id  = '0;
		sw_we    = 1'b0;
		rq_raddr = rhead_q;
		case (cmd.op)
			OP_EXEC: begin
				case (kind_t'(kind_q))
					K_CREATE: begin
						if (create_ok) begin
							push_req = 1'b1;
							push_id  = IW'(next_q);
						end
					end
					K_YIELD: begin
						if (running_q != '0) begin
							push_req = 1'b1;
							push_id  = running_q;
						end
						phase = PH_DISPATCH;
					end
					K_JOIN:       if (join_block) phase = PH_DISPATCH;
					K_JOIN_ALL:   if (running_q != '0) phase = PH_JA;
					K_EXIT:       if (running_q != '0) phase = PH_EX;
					K_SEM_SIGNAL: if (sig_pop) phase = PH_POP;
					K_SEM_WAIT: begin
						if (wait_block) phase = PH_DISPATCH;
						sw_we = wait_store;
					end
					default: phase = PH_DONE;
				endcase
			end
			OP_JA_STEP: rq_raddr = ja_ptr;
			OP_EX_WAKE: begin
				push_req = wake;
				push_id  = par_q;
			end
			OP_SEM_PUSH: begin
				push_req = 1'b1;
				push_id  = sw_rdata_q;
			end
			default: push_req = 1'b0;
		endcase
	end

	assign rq_we = push_req && (rcount_q < IW'(MT));

	assign stat.exec_next = phase;
	assign stat.ja_last   = (idx_q >= rcount_q);
	assign stat.ex_last   = (idx_q == IW'(MT - 1));
	assign stat.ja_take   = any_q || ja_hit;
	assign stat.out_free  = !ov_q || out_ready;

	// ready queue memory
	always_ff @(posedge clk) begin
		if (rq_we) rq_mem[rtail] <= push_id;
		rq_rdata_q <= rq_mem[rq_raddr];
	end

	// semaphore wait list memory
	always_ff @(posedge clk) begin
		if (sw_we) sw_mem[sw_waddr] <= running_q;
		sw_rdata_q <= sw_mem[sw_raddr];
	end

	// request latch, parents and counts (no reset: written before read)
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			kind_q <= in_kind;
			tgt_q  <= in_target;
			sh_q   <= in_sem;
			init_q <= in_initial;
		end
		if (cmd.op == OP_EXEC) begin
			case (kind_t'(kind_q))
				// the main thread starts with no parent
				K_INIT:       parent_q[TW'(MAIN_THREAD_ID - 1)] <= '0;
				K_CREATE:     if (create_ok) parent_q[create_slot] <= running_q;
				K_SEM_INIT:   if (free_found) sval_q[free_idx] <= init_clamp;
				K_SEM_SIGNAL: if (sem_ok) sval_q[si] <= sig_inc;
				K_SEM_WAIT:   if (sem_ok) sval_q[si] <= wait_dec;
				default:      ;
			endcase
		end
		if (cmd.op == OP_EX_STEP && hit_me) parent_q[ex_slot] <= new_par;
	end

	// control and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rhead_q   <= '0;
			rcount_q  <= '0;
			running_q <= '0;
			next_q    <= NW'(1);
			live_q    <= '0;
			fin_q     <= '0;
			blk_q     <= '0;
			sused_q   <= '0;
			for (int i = 0; i < MT; i++) waits_q[i] <= '0;
			for (int i = 0; i < MS; i++) begin
				shead_q[i] <= '0;
				scnt_q[i]  <= '0;
			end
			idx_q    <= '0;
			par_q    <= '0;
			any_q    <= 1'b0;
			jv_q     <= 1'b0;
			hc_q     <= 1'b0;
			status_q <= STS_OK;
			handle_q <= '0;
			ov_q     <= 1'b0;
			ost_q    <= STS_OK;
			orun_q   <= '0;
			ohd_q    <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					status_q <= STS_OK;
					handle_q <= '0;
					idx_q    <= '0;
					any_q    <= 1'b0;
					jv_q     <= 1'b0;
					hc_q     <= 1'b0;
				end
				OP_EXEC: begin
					case (kind_t'(kind_q))
						K_INIT: begin
							rhead_q   <= '0;
							rcount_q  <= '0;
							live_q    <= MT'(1);
							fin_q     <= '0;
							blk_q     <= '0;
							sused_q   <= '0;
							for (int i = 0; i < MT; i++) waits_q[i] <= '0;
							for (int i = 0; i < MS; i++) begin
								shead_q[i] <= '0;
								scnt_q[i]  <= '0;
							end
							running_q <= main_id;
							next_q    <= NW'(2);
							handle_q  <= ID_W'(MAIN_THREAD_ID);
						end
						K_CREATE: begin
							if (create_ok) begin
								handle_q               <= ID_W'(next_q);
								live_q[create_slot]    <= 1'b1;
								fin_q[create_slot]     <= 1'b0;
								blk_q[create_slot]     <= 1'b0;
								waits_q[create_slot]   <= '0;
								next_q                 <= next_q + NW'(1);
							end else begin
								status_q <= STS_NO_THREAD;
							end
						end
						K_JOIN: begin
							if (j_bad1 || (!j_fin && j_bad2)) status_q <= STS_NOT_CHILD;
							if (join_block) begin
								waits_q[run_slot] <= IW'(tgt_q);
								blk_q[run_slot]   <= 1'b1;
							end
						end
						K_EXIT: begin
							if (running_q != '0) begin
								fin_q[run_slot] <= 1'b1;
								par_q           <= parent_q[run_slot];
							end
						end
						K_SEM_INIT: begin
							if (free_found) begin
								sused_q[free_idx] <= 1'b1;
								shead_q[free_idx] <= '0;
								scnt_q[free_idx]  <= '0;
								handle_q          <= ID_W'(free_idx);
							end else begin
								status_q <= STS_NO_SEM;
							end
						end
						K_SEM_SIGNAL: begin
							if (sig_pop) begin
								shead_q[si] <= (shead_cur == TW'(MT - 1)) ? '0
								               : shead_cur + TW'(1);
								scnt_q[si]  <= scnt_cur - IW'(1);
							end
						end
						K_SEM_WAIT: begin
							if (wait_store) scnt_q[si] <= scnt_cur + IW'(1);
						end
						K_SEM_DESTROY: begin
							if (sem_ok) begin
								if (scnt_cur != '0) status_q <= STS_SEM_BUSY;
								else sused_q[si] <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				OP_JA_STEP: begin
					if (ja_hit) any_q <= 1'b1;
					jv_q  <= (idx_q < rcount_q);
					idx_q <= idx_q + IW'(1);
				end
				OP_JA_END: begin
					if (any_q || ja_hit) blk_q[run_slot] <= 1'b1;
				end
				OP_EX_STEP: begin
					if (hit_par) hc_q <= 1'b1;
					idx_q <= idx_q + IW'(1);
				end
				OP_EX_WAKE: begin
					if (wake) blk_q[par_slot] <= 1'b0;
					if (wake_clear) waits_q[par_slot] <= '0;
				end
				OP_DISP_WR: begin
					if (rcount_q == '0) begin
						running_q <= '0;
					end else begin
						running_q <= rq_rdata_q;
						rhead_q   <= (rhead_q == TW'(MT - 1)) ? '0 : rhead_q + TW'(1);
						rcount_q  <= rcount_q - IW'(1);
					end
				end
				default: ;
			endcase

			// append to the ready queue
			if (rq_we) rcount_q <= rcount_q + IW'(1);

			// result register
			if (cmd.op == OP_RESULT) begin
				ov_q   <= 1'b1;
				ost_q  <= status_q;
				orun_q <= ID_W'(running_q);
				ohd_q  <= handle_q;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid   = ov_q;
	assign out_status  = ost_q;
	assign out_running = orun_q;
	assign out_idle    = (orun_q == '0);
	assign out_handle  = ohd_q;

endmodule
